@@ hw/rtl/fsta_pkg.sv @@
// Shared constants and types for the file slot table allocator.
`timescale 1ns / 1ps

package fsta_pkg;

   // Default table sizes.
   localparam int SLOTS_DEF  = 32;
   localparam int BLOCKS_DEF = 512;

   // Field widths of the item ports.
   localparam int CMD_W      = 2;
   localparam int ID_W       = 31;
   localparam int STAT_W     = 3;
   localparam int SLOT_OUT_W = 5;
   localparam int BLK_OUT_W  = 9;

   // The block bitmap is kept as words of this many bits.
   localparam int WORD_W = 32;
   localparam int BIT_W  = $clog2(WORD_W);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_EXISTS    = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NO_SLOT   = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NO_BLOCK  = 3'd4;

   // Search token that walks down the slot chain.
   typedef struct packed {
      logic valid;  // a search is at this cell
      logic hit;    // an earlier cell held the identifier
      logic free;   // an earlier cell was empty
   } token_type;

   // Slot update broadcast to every cell.
   typedef struct packed {
      logic en;     // update the addressed slot
      logic set;    // 1 fills the slot, 0 empties it
   } slot_wr_type;

endpackage

@@ hw/rtl/fsta_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module fsta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ hw/rtl/fsta_slot_cell.sv @@
// One file slot of the slot chain: holds the slot and passes the search token on.
`timescale 1ns / 1ps

module fsta_slot_cell #(
   parameter int SLOTS  = fsta_pkg::SLOTS_DEF,
   parameter int BLOCKS = fsta_pkg::BLOCKS_DEF,
   parameter int IDX    = 0,
   parameter int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   parameter int BW     = $clog2(BLOCKS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fsta_pkg::token_type     tok_in,
   input  logic [SW-1:0]           hit_idx_in,
   input  logic [BW-1:0]           hit_blk_in,
   input  logic [SW-1:0]           free_idx_in,
   output fsta_pkg::token_type     tok_out,
   output logic [SW-1:0]           hit_idx_out,
   output logic [BW-1:0]           hit_blk_out,
   output logic [SW-1:0]           free_idx_out,
   input  logic [fsta_pkg::ID_W-1:0] id,
   input  fsta_pkg::slot_wr_type   wr,
   input  logic [SW-1:0]           wr_idx,
   input  logic [BW-1:0]           wr_blk
);

   localparam logic [SW-1:0] MY_IDX = SW'(IDX);

   logic                      valid_ff;
   logic [fsta_pkg::ID_W-1:0] id_ff;
   logic [BW-1:0]             blk_ff;

   fsta_pkg::token_type tok_ff, tok_in_nxt;
   logic [SW-1:0]       hit_idx_ff, hit_idx_in_nxt;
   logic [BW-1:0]       hit_blk_ff, hit_blk_in_nxt;
   logic [SW-1:0]       free_idx_ff, free_idx_in_nxt;
   logic                match, take_free;

   // The first matching cell and the first empty cell claim the token.
   always_comb begin
      match           = valid_ff && (id_ff == id) && !tok_in.hit;
      take_free       = !valid_ff && !tok_in.free;
      tok_in_nxt.valid = tok_in.valid;
      tok_in_nxt.hit   = tok_in.hit | match;
      tok_in_nxt.free  = tok_in.free | !valid_ff;
      hit_idx_in_nxt  = match ? MY_IDX : hit_idx_in;
      hit_blk_in_nxt  = match ? blk_ff : hit_blk_in;
      free_idx_in_nxt = take_free ? MY_IDX : free_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_nxt.valid;
         if (wr.en && (wr_idx == MY_IDX)) begin
            valid_ff <= wr.set;
         end
      end
      if (wr.en && wr.set && (wr_idx == MY_IDX)) begin
         id_ff  <= id;
         blk_ff <= wr_blk;
      end
      tok_ff.hit  <= tok_in_nxt.hit;
      tok_ff.free <= tok_in_nxt.free;
      hit_idx_ff  <= hit_idx_in_nxt;
      hit_blk_ff  <= hit_blk_in_nxt;
      free_idx_ff <= free_idx_in_nxt;
   end

   assign tok_out      = tok_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign hit_blk_out  = hit_blk_ff;
   assign free_idx_out = free_idx_ff;

endmodule

@@ hw/rtl/file_slot_table_allocator_top.sv @@
// Top level of the file slot table allocator: slot chain, bitmap RAM and control.
// Flow: a search token enters the slot chain in the cycle after acceptance and crosses it;
// a lookup answers once it leaves the chain; a delete then reads and rewrites one bitmap
// word; a create reads 32-bit bitmap words in turn, at most WORDS, until one has a free bit.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: synchronous; all slots empty, bitmap rows read as reset value (blocks 0, 1 used).
`timescale 1ns / 1ps

module file_slot_table_allocator_top #(
   parameter int SLOTS  = fsta_pkg::SLOTS_DEF,
   parameter int BLOCKS = fsta_pkg::BLOCKS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fsta_pkg::CMD_W-1:0]    req_cmd,
   input  logic [fsta_pkg::ID_W-1:0]     req_file_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic [fsta_pkg::STAT_W-1:0]   rsp_status,
   output logic [fsta_pkg::SLOT_OUT_W-1:0] rsp_slot_index,
   output logic [fsta_pkg::BLK_OUT_W-1:0]  rsp_block_number
);

   // Sizes derived from the parameters.
   localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BW        = $clog2(BLOCKS);
   localparam int WW        = fsta_pkg::WORD_W;
   localparam int WORDS     = (BLOCKS + WW - 1) / WW;
   localparam int WAW       = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BXW       = WAW + fsta_pkg::BIT_W;
   localparam int LAST_BITS = BLOCKS - (WORDS - 1) * WW;

   localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
   localparam logic [WW-1:0]  ALL_ONES  = {WW{1'b1}};
   // Bits of the last word that lie beyond the last block are treated as used.
   localparam logic [WW-1:0]  LAST_MASK = ALL_ONES >> (WW - LAST_BITS);
   // The formatted disk has blocks 0 and 1 in use; every other row starts empty.
   localparam logic [WW-1:0]  ROW0_RESET = WW'(3);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_BRD, S_BCHK, S_DRD, S_DWR, S_RESP
   } state_type;

   state_type state_ff, state_in;

   // Item being worked on.
   logic [fsta_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [fsta_pkg::ID_W-1:0]  id_ff, id_in;
   logic [SW-1:0]              slot_ff, slot_in;
   logic [BW-1:0]              blk_ff, blk_in;
   logic [WAW-1:0]             word_ff, word_in;

   // Launches the search token once the identifier register holds the new item.
   logic                       start_ff, start_in;

   // Pending result, and the output register that feeds the result port.
   logic                        res_ok_ff, res_ok_in;
   logic [fsta_pkg::STAT_W-1:0] res_st_ff, res_st_in;
   logic [SW-1:0]               res_slot_ff, res_slot_in;
   logic [BW-1:0]               res_blk_ff, res_blk_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_ok_ff, rsp_ok_in;
   logic [fsta_pkg::STAT_W-1:0]   rsp_st_ff, rsp_st_in;
   logic [fsta_pkg::SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [fsta_pkg::BLK_OUT_W-1:0]  rsp_blk_ff, rsp_blk_in;

   // Bitmap row valid bits: a row never written reads as its reset value.
   logic [WORDS-1:0] row_valid_ff, row_valid_in;

   // Slot chain wiring.
   fsta_pkg::token_type tok      [SLOTS+1];
   logic [SW-1:0]       hit_idx  [SLOTS+1];
   logic [BW-1:0]       hit_blk  [SLOTS+1];
   logic [SW-1:0]       free_idx [SLOTS+1];

   fsta_pkg::slot_wr_type slot_wr;
   logic [SW-1:0]         slot_wr_idx;
   logic [BW-1:0]         slot_wr_blk;

   // Bitmap RAM wiring.
   logic           ram_wr_en;
   logic [WAW-1:0] cur_word;
   logic [WW-1:0]  ram_wr_data;
   logic [WW-1:0]  ram_rd_data;
   logic [WW-1:0]  row_word;
   logic [WW-1:0]  row_used;
   logic           row_has_free;
   logic [fsta_pkg::BIT_W-1:0] free_bit;
   logic [BXW-1:0] del_bx;
   logic [BXW-1:0] new_bx;

   logic req_accept;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);

   // The search token enters cell 0 in the cycle after the item is accepted, when every
   // cell already compares against the new identifier.
   assign tok[0].valid = start_ff;
   assign tok[0].hit   = 1'b0;
   assign tok[0].free  = 1'b0;
   assign hit_idx[0]   = '0;
   assign hit_blk[0]   = '0;
   assign free_idx[0]  = '0;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      fsta_slot_cell #(
         .SLOTS  (SLOTS),
         .BLOCKS (BLOCKS),
         .IDX    (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .tok_in       (tok[g]),
         .hit_idx_in   (hit_idx[g]),
         .hit_blk_in   (hit_blk[g]),
         .free_idx_in  (free_idx[g]),
         .tok_out      (tok[g+1]),
         .hit_idx_out  (hit_idx[g+1]),
         .hit_blk_out  (hit_blk[g+1]),
         .free_idx_out (free_idx[g+1]),
         .id           (id_ff),
         .wr           (slot_wr),
         .wr_idx       (slot_wr_idx),
         .wr_blk       (slot_wr_blk)
      );
   end

   // The bitmap word in use: the scan pointer for a create, the freed block's word for a
   // delete.
   assign del_bx   = BXW'(blk_ff);
   assign cur_word = ((state_ff == S_DRD) || (state_ff == S_DWR)) ?
                     del_bx[BXW-1:fsta_pkg::BIT_W] : word_ff;

   fsta_ram #(
      .WIDTH (WW),
      .DEPTH (WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cur_word),
      .wr_data (ram_wr_data),
      .rd_addr (cur_word),
      .rd_data (ram_rd_data)
   );

   // Row as it stands, then with the blocks past the end marked used, and its lowest free bit.
   always_comb begin
      if (row_valid_ff[cur_word]) begin
         row_word = ram_rd_data;
      end else if (cur_word == '0) begin
         row_word = ROW0_RESET;
      end else begin
         row_word = '0;
      end
      row_used = (cur_word == LAST_WORD) ? (row_word | ~LAST_MASK) : row_word;
      row_has_free = (row_used != ALL_ONES);
      free_bit = '0;
      for (int j = WW - 1; j >= 0; j--) begin
         if (!row_used[j]) begin
            free_bit = fsta_pkg::BIT_W'(j);
         end
      end
   end

   assign new_bx = {word_ff, free_bit};

   // Control: next values of state, item registers, bitmap and slot writes.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      slot_in      = slot_ff;
      blk_in       = blk_ff;
      word_in      = word_ff;
      start_in     = 1'b0;
      res_ok_in    = res_ok_ff;
      res_st_in    = res_st_ff;
      res_slot_in  = res_slot_ff;
      res_blk_in   = res_blk_ff;
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_blk_in   = rsp_blk_ff;
      ram_wr_en    = 1'b0;
      ram_wr_data  = row_word;
      slot_wr.en   = 1'b0;
      slot_wr.set  = 1'b0;
      slot_wr_idx  = slot_ff;
      slot_wr_blk  = new_bx[BW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in   = req_cmd;
               id_in    = req_file_id;
               start_in = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (tok[SLOTS].valid) begin
               res_ok_in   = 1'b0;
               res_st_in   = fsta_pkg::STAT_NOT_FOUND;
               res_slot_in = '0;
               res_blk_in  = '0;
               state_in    = S_RESP;
               unique case (cmd_ff)
                  fsta_pkg::CMD_LOOKUP: begin
                     if (tok[SLOTS].hit) begin
                        res_ok_in   = 1'b1;
                        res_st_in   = fsta_pkg::STAT_OK;
                        res_slot_in = hit_idx[SLOTS];
                        res_blk_in  = hit_blk[SLOTS];
                     end
                  end
                  fsta_pkg::CMD_CREATE: begin
                     if (tok[SLOTS].hit) begin
                        res_st_in = fsta_pkg::STAT_EXISTS;
                     end else if (!tok[SLOTS].free) begin
                        res_st_in = fsta_pkg::STAT_NO_SLOT;
                     end else begin
                        slot_in  = free_idx[SLOTS];
                        word_in  = '0;
                        state_in = S_BRD;
                     end
                  end
                  fsta_pkg::CMD_DELETE: begin
                     if (tok[SLOTS].hit) begin
                        slot_in  = hit_idx[SLOTS];
                        blk_in   = hit_blk[SLOTS];
                        state_in = S_DRD;
                     end
                  end
                  default: begin
                     // Unused command: not found, nothing changes.
                  end
               endcase
            end
         end
         S_BRD: begin
            state_in = S_BCHK;
         end
         S_BCHK: begin
            if (row_has_free) begin
               ram_wr_en              = 1'b1;
               ram_wr_data            = row_word | (WW'(1) << free_bit);
               row_valid_in[cur_word] = 1'b1;
               slot_wr.en             = 1'b1;
               slot_wr.set            = 1'b1;
               res_ok_in              = 1'b1;
               res_st_in              = fsta_pkg::STAT_OK;
               res_slot_in            = slot_ff;
               res_blk_in             = new_bx[BW-1:0];
               state_in               = S_RESP;
            end else if (word_ff == LAST_WORD) begin
               res_st_in = fsta_pkg::STAT_NO_BLOCK;
               state_in  = S_RESP;
            end else begin
               word_in  = word_ff + WAW'(1);
               state_in = S_BRD;
            end
         end
         S_DRD: begin
            state_in = S_DWR;
         end
         S_DWR: begin
            ram_wr_en              = 1'b1;
            ram_wr_data            = row_word & ~(WW'(1) << del_bx[fsta_pkg::BIT_W-1:0]);
            row_valid_in[cur_word] = 1'b1;
            slot_wr.en             = 1'b1;
            slot_wr.set            = 1'b0;
            res_ok_in              = 1'b1;
            res_st_in              = fsta_pkg::STAT_OK;
            res_slot_in            = slot_ff;
            res_blk_in             = blk_ff;
            state_in               = S_RESP;
         end
         S_RESP: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_st_in    = res_st_ff;
               rsp_slot_in  = fsta_pkg::SLOT_OUT_W'(res_slot_ff);
               rsp_blk_in   = fsta_pkg::BLK_OUT_W'(res_blk_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
      end
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      slot_ff     <= slot_in;
      blk_ff      <= blk_in;
      word_ff     <= word_in;
      res_ok_ff   <= res_ok_in;
      res_st_ff   <= res_st_in;
      res_slot_ff <= res_slot_in;
      res_blk_ff  <= res_blk_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_blk_ff  <= rsp_blk_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_block_number = rsp_blk_ff;

   // A search token leaves the chain only while control waits for it.
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[SLOTS].valid |-> (state_ff == S_SCAN))
      else $error("search token left the slot chain outside the scan state");

   // A successful result always carries the ok status.
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ok) |-> (rsp_status == fsta_pkg::STAT_OK))
      else $error("ok result with a failure status");

   // A failed result carries no slot and no block.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> ((rsp_slot_index == '0) && (rsp_block_number == '0)))
      else $error("failed result with a slot or block");

endmodule
